### rtl/core/epc_pkg.sv
// ----------------------------------------------------------------------------
// Even partition calculator: shared definitions
// Request codes, result error codes, configuration register indexes and the
// status bundle that the configuration unit hands to the front end.
// ----------------------------------------------------------------------------
package epc_pkg;

  // Width of the piece size field of a result
  localparam int COUNT_BITS = 31;

  // Width of the error code field of a result
  localparam int ERR_BITS = 2;

  // Width of the configuration register index
  localparam int CFG_INDEX_BITS = 1;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_OK    = 2'd0,
    ERR_SHARE = 2'd1,
    ERR_RANGE = 2'd2
  } err_code_e;

  typedef enum logic {
    OP_RANGE  = 1'b0,
    OP_LOCATE = 1'b1
  } op_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TOTAL_ITEMS = 1'b0,
    REG_PIECE_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic busy;
    logic zero_pieces;
    logic share_over;
  } cfg_status_t;

endpackage

### rtl/core/epc_if.sv
// ----------------------------------------------------------------------------
// Even partition calculator: request and result channels
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface epc_req_if #(
  parameter int TOTAL_BITS = 40,
  parameter int PIECE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [PIECE_BITS-1:0] piece_number;
  logic [TOTAL_BITS-1:0] item_index;

  modport source (output valid, output operation, output piece_number,
                  output item_index, input ready);
  modport sink   (input valid, input operation, input piece_number,
                  input item_index, output ready);
endinterface

interface epc_res_if #(
  parameter int TOTAL_BITS = 40,
  parameter int PIECE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [TOTAL_BITS-1:0]         first_item;
  logic [epc_pkg::COUNT_BITS-1:0] item_count;
  logic [PIECE_BITS-1:0]         owning_piece;
  logic [epc_pkg::ERR_BITS-1:0]  error_code;

  modport source (output valid, output first_item, output item_count,
                  output owning_piece, output error_code, input ready);
  modport sink   (input valid, input first_item, input item_count,
                  input owning_piece, input error_code, output ready);
endinterface

### rtl/core/epc_cfg.sv
// ----------------------------------------------------------------------------
// Even partition calculator: configuration unit
// Holds the two registers and, after each write, derives the base share and
// remainder (one quotient bit a cycle) and the span of the larger pieces
// (one multiplier bit a cycle).
// ----------------------------------------------------------------------------
module epc_cfg #(
  parameter int TOTAL_BITS = 40,
  parameter int PIECE_BITS = 16,
  parameter int CFG_W      = 40
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [epc_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]                   cfg_data_i,
  output logic [TOTAL_BITS-1:0]              total_o,
  output logic [PIECE_BITS-1:0]              piece_o,
  output logic [TOTAL_BITS-1:0]              base_o,
  output logic [PIECE_BITS-1:0]              extra_o,
  output logic [TOTAL_BITS-1:0]              big_span_o,
  output epc_pkg::cfg_status_t               status_o
);
  import epc_pkg::*;

  localparam int TB    = TOTAL_BITS;
  localparam int PB    = PIECE_BITS;
  localparam int MAX_W = (TB > PB) ? TB : PB;
  localparam int CW    = $clog2(MAX_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_SPAN
  } state_e;

  state_e          state_q, state_d;
  logic [TB-1:0]   total_q, total_d;
  logic [PB-1:0]   piece_q, piece_d;
  logic [TB-1:0]   quo_q, quo_d;
  logic [PB:0]     rem_q, rem_d;
  logic [TB:0]     acc_q, acc_d;
  logic [CW-1:0]   step_q, step_d;
  logic [PB-1:0]   extra_q, extra_d;
  logic [TB-1:0]   span_q, span_d;
  logic            zero_q, zero_d;
  logic            share_q, share_d;

  logic [PB:0]     rem_sh;
  logic            rem_ge;
  logic [TB:0]     addend;

  // Next state: a write restarts the derivation, otherwise step the sequencer
  always_comb begin
    state_d = state_q;
    total_d = total_q;
    piece_d = piece_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    step_d  = step_q;
    extra_d = extra_q;
    span_d  = span_q;
    zero_d  = zero_q;
    share_d = share_q;

    rem_sh = {rem_q[PB-1:0], quo_q[TB-1]};
    rem_ge = (rem_sh >= {1'b0, piece_q});
    addend = rem_q[PB-1] ? ({1'b0, quo_q} + (TB+1)'(1)) : '0;

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TOTAL_ITEMS: total_d = TB'(cfg_data_i);
        REG_PIECE_COUNT: piece_d = PB'(cfg_data_i);
      endcase
      state_d = ST_START;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
        end
        ST_START: begin
          if (piece_q == '0) begin
            zero_d  = 1'b1;
            share_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            zero_d  = 1'b0;
            quo_d   = total_q;
            rem_d   = '0;
            step_d  = CW'(TB - 1);
            state_d = ST_DIVIDE;
          end
        end
        // One restoring step: quotient bits shift in behind the dividend
        ST_DIVIDE: begin
          rem_d = rem_ge ? (rem_sh - {1'b0, piece_q}) : rem_sh;
          quo_d = {quo_q[TB-2:0], rem_ge};
          if (step_q == '0) begin
            extra_d = rem_d[PB-1:0];
            share_d = ((quo_d >> COUNT_BITS) != '0);
            acc_d   = '0;
            step_d  = CW'(PB - 1);
            state_d = ST_SPAN;
          end else begin
            step_d = step_q - CW'(1);
          end
        end
        // Span of the larger pieces, remainder bits taken MSB first
        ST_SPAN: begin
          acc_d = (acc_q << 1) + addend;
          rem_d = rem_q << 1;
          if (step_q == '0) begin
            span_d  = TB'(acc_d);
            state_d = ST_IDLE;
          end else begin
            step_d = step_q - CW'(1);
          end
        end
      endcase
    end
  end

  // Hold state, registers and derived values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      piece_q <= PB'(1);
      quo_q   <= '0;
      rem_q   <= '0;
      acc_q   <= '0;
      step_q  <= '0;
      extra_q <= '0;
      span_q  <= '0;
      zero_q  <= 1'b0;
      share_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      piece_q <= piece_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      step_q  <= step_d;
      extra_q <= extra_d;
      span_q  <= span_d;
      zero_q  <= zero_d;
      share_q <= share_d;
    end
  end

  assign total_o    = total_q;
  assign piece_o    = piece_q;
  assign base_o     = quo_q;
  assign extra_o    = extra_q;
  assign big_span_o = span_q;
  assign status_o   = '{busy: (state_q != ST_IDLE), zero_pieces: zero_q,
                        share_over: share_q};

endmodule

### rtl/core/epc_front.sv
// ----------------------------------------------------------------------------
// Even partition calculator: front end
// Accepts requests, settles the error code and prepares the division operands
// for a locate request and the offset terms for a range request.
// ----------------------------------------------------------------------------
module epc_front #(
  parameter int TOTAL_BITS = 40,
  parameter int PIECE_BITS = 16,
  parameter int QW         = 2 * TOTAL_BITS + 2 * PIECE_BITS + 5
) (
  epc_req_if.sink                 req,
  input  logic                    cfg_we_i,
  input  logic [TOTAL_BITS-1:0]   total_i,
  input  logic [PIECE_BITS-1:0]   piece_i,
  input  logic [TOTAL_BITS-1:0]   base_i,
  input  logic [PIECE_BITS-1:0]   extra_i,
  input  logic [TOTAL_BITS-1:0]   big_span_i,
  input  epc_pkg::cfg_status_t    status_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output logic [QW-1:0]           entry_o
);
  import epc_pkg::*;

  localparam int TB = TOTAL_BITS;
  localparam int PB = PIECE_BITS;

  typedef struct packed {
    logic          op;
    logic [1:0]    err;
    logic          inc;
    logic [PB-1:0] pnum;
    logic [PB-1:0] minp;
    logic [TB:0]   divisor;
    logic [TB-1:0] dividend;
  } entry_t;

  entry_t    entry;
  err_code_e err;
  logic      idx_oob;
  logic      in_big;
  logic      pnum_oob;
  logic      below_extra;

  // Take a request while the queue has room and the derived values are valid
  assign req.ready = !q_full_i && !status_i.busy && !cfg_we_i;
  assign push_o    = req.valid && req.ready;

  // Classify the request
  always_comb begin
    idx_oob     = (req.item_index >= total_i);
    in_big      = (req.item_index < big_span_i);
    pnum_oob    = (req.piece_number >= piece_i);
    below_extra = (req.piece_number < extra_i);

    if (status_i.zero_pieces) begin
      err = ERR_RANGE;
    end else if (req.operation == OP_RANGE) begin
      if (status_i.share_over) begin
        err = ERR_SHARE;
      end else if (pnum_oob) begin
        err = ERR_RANGE;
      end else begin
        err = ERR_OK;
      end
    end else if (idx_oob) begin
      err = ERR_RANGE;
    end else begin
      err = ERR_OK;
    end

    entry.op   = req.operation;
    entry.err  = err;
    entry.inc  = below_extra;
    entry.pnum = req.piece_number;
    entry.minp = below_extra ? req.piece_number : extra_i;
    // Larger pieces divide by base+1, the rest by base after the extra items
    if (in_big) begin
      entry.dividend = req.item_index;
      entry.divisor  = {1'b0, base_i} + (TB+1)'(1);
    end else begin
      entry.dividend = req.item_index - TB'(extra_i);
      entry.divisor  = {1'b0, base_i};
    end
  end

  assign entry_o = entry;

endmodule

### rtl/core/epc_queue.sv
// ----------------------------------------------------------------------------
// Even partition calculator: request queue
// Short flop queue between front end and back end.
// ----------------------------------------------------------------------------
module epc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      count_q;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      count_q <= count_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

### rtl/core/epc_back.sv
// ----------------------------------------------------------------------------
// Even partition calculator: back end
// Pipelined restoring divider, one quotient bit per stage, with the range
// product and sum carried alongside. The last stage is the result register.
// ----------------------------------------------------------------------------
module epc_back #(
  parameter int TOTAL_BITS = 40,
  parameter int PIECE_BITS = 16,
  parameter int QW         = 2 * TOTAL_BITS + 2 * PIECE_BITS + 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  logic [QW-1:0]         head_i,
  output logic                  pop_o,
  input  logic [TOTAL_BITS-1:0] base_i,
  epc_res_if.source             res
);
  import epc_pkg::*;

  localparam int TB   = TOTAL_BITS;
  localparam int PB   = PIECE_BITS;
  localparam int WD   = TB + PB + 1;
  localparam int PW   = PB + COUNT_BITS;
  localparam int LAST = PB - 1;

  typedef struct packed {
    logic          op;
    logic [1:0]    err;
    logic          inc;
    logic [PB-1:0] pnum;
    logic [PB-1:0] minp;
    logic [TB:0]   divisor;
    logic [TB-1:0] dividend;
  } entry_t;

  typedef struct packed {
    logic                  op;
    logic [1:0]            err;
    logic                  inc;
    logic [PB-1:0]         minp;
    logic [TB:0]           divisor;
    logic [TB-1:0]         rem;
    logic [PB-1:0]         quo;
    logic [TB-1:0]         first;
    logic [COUNT_BITS-1:0] count;
  } stage_t;

  entry_t                head;
  stage_t                src     [PB];
  stage_t                stage_d [PB];
  stage_t                stage_q [PB];
  logic   [PB-1:0]       valid_q;
  logic                  adv;
  logic [COUNT_BITS-1:0] base_cnt;
  logic [PW-1:0]         prod;
  logic [WD-1:0]         shifted [PB];

  assign head     = entry_t'(head_i);
  assign base_cnt = COUNT_BITS'(base_i);
  assign adv      = !valid_q[LAST] || res.ready;
  assign pop_o    = adv && head_valid_i;

  // Stage inputs, then one division step per stage
  always_comb begin
    prod = PW'(head.pnum) * PW'(base_cnt);

    src[0].op      = head.op;
    src[0].err     = head.err;
    src[0].inc     = head.inc;
    src[0].minp    = head.minp;
    src[0].divisor = head.divisor;
    src[0].rem     = head.dividend;
    src[0].quo     = '0;
    src[0].first   = TB'(prod);
    src[0].count   = '0;
    for (int i = 1; i < PB; i++) begin
      src[i] = stage_q[i-1];
      if (i == 1) begin
        src[i].first = stage_q[0].first + TB'(stage_q[0].minp);
        src[i].count = base_cnt + COUNT_BITS'(stage_q[0].inc);
      end
    end

    for (int i = 0; i < PB; i++) begin
      stage_d[i] = src[i];
      shifted[i] = WD'(src[i].divisor) << (PB - 1 - i);
      if (WD'(src[i].rem) >= shifted[i]) begin
        stage_d[i].rem            = TB'(WD'(src[i].rem) - shifted[i]);
        stage_d[i].quo[PB-1-i]    = 1'b1;
      end
    end
  end

  // Advance the valid flags when the result slot frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[PB-2:0], head_valid_i};
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < PB; i++) begin
        stage_q[i] <= stage_d[i];
      end
    end
  end

  // Drive the result, zeroing fields that do not apply
  always_comb begin
    res.valid        = valid_q[LAST];
    res.error_code   = stage_q[LAST].err;
    res.first_item   = '0;
    res.item_count   = '0;
    res.owning_piece = '0;
    if (stage_q[LAST].err == ERR_OK) begin
      if (stage_q[LAST].op == OP_RANGE) begin
        res.first_item = stage_q[LAST].first;
        res.item_count = stage_q[LAST].count;
      end else begin
        res.owning_piece = stage_q[LAST].quo;
      end
    end
  end

endmodule

### rtl/core/even_partition_calculator.sv
// ----------------------------------------------------------------------------
// Even partition calculator
// Splits a configured item total into pieces whose sizes differ by at most
// one, and answers range and locate requests against that split.
// ----------------------------------------------------------------------------
// Usage:
//   Write total_items (index 0) and piece_count (index 1) on the plain write
//   port while no request is in flight. Each write starts a derivation of the
//   base share, remainder and large-piece span, and the request channel
//   holds ready low until it is done.
//   Requests enter on req (valid/ready); each gives exactly one result on res,
//   in order, from the divider pipeline of one quotient bit per stage. A new
//   request is taken every cycle while res.ready is high and no derivation
//   runs.
//   When the receiver holds res.ready low, the pipeline stalls and the
//   four-entry request queue keeps taking requests until it fills.
//   Reset empties the pipeline and queue and loads total_items 0 and
//   piece_count 1.
// ----------------------------------------------------------------------------
module even_partition_calculator #(
  parameter int  TOTAL_BITS = 40,
  parameter int  PIECE_BITS = 16,
  localparam int CFG_W      = (TOTAL_BITS > PIECE_BITS) ? TOTAL_BITS : PIECE_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [epc_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]                   cfg_data_i,
  epc_req_if.sink                            req,
  epc_res_if.source                          res
);
  import epc_pkg::*;

  localparam int QW       = 2 * TOTAL_BITS + 2 * PIECE_BITS + 5;
  localparam int Q_DEPTH  = 4;

  logic [TOTAL_BITS-1:0] total;
  logic [PIECE_BITS-1:0] piece;
  logic [TOTAL_BITS-1:0] base;
  logic [PIECE_BITS-1:0] extra;
  logic [TOTAL_BITS-1:0] big_span;
  cfg_status_t           status;
  logic                  q_full;
  logic                  push;
  logic [QW-1:0]         push_entry;
  logic                  pop;
  logic                  head_valid;
  logic [QW-1:0]         head;

  epc_cfg #(
    .TOTAL_BITS (TOTAL_BITS),
    .PIECE_BITS (PIECE_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .total_o    (total),
    .piece_o    (piece),
    .base_o     (base),
    .extra_o    (extra),
    .big_span_o (big_span),
    .status_o   (status)
  );

  epc_front #(
    .TOTAL_BITS (TOTAL_BITS),
    .PIECE_BITS (PIECE_BITS),
    .QW         (QW)
  ) u_front (
    .req        (req),
    .cfg_we_i   (cfg_we_i),
    .total_i    (total),
    .piece_i    (piece),
    .base_i     (base),
    .extra_i    (extra),
    .big_span_i (big_span),
    .status_i   (status),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  epc_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  epc_back #(
    .TOTAL_BITS (TOTAL_BITS),
    .PIECE_BITS (PIECE_BITS),
    .QW         (QW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .base_i       (base),
    .res          (res)
  );

endmodule
